// ----- hw/rtl/ebcd_pkg.sv -----
// Package for the eMMC boot command detector: ring size, command codes,
// payload structs and the byte-swap / ring-word helpers.
// No dependencies.
`timescale 1ns / 1ps

package ebcd_pkg;

  // Ring geometry
  localparam int RING_WORDS  = 4;
  localparam int INPUT_WORDS = 4;
  localparam int WORD_W      = 32;
  localparam int POS_W       = 2;

  // Bus patterns
  localparam logic [WORD_W-1:0] ALL_ONES = 32'hffff_ffff;
  localparam logic [WORD_W-1:0] IDLE_HI  = 32'h4000_0000;
  localparam logic [WORD_W-1:0] IDLE_LO  = 32'h0095_ffff;
  localparam logic [WORD_W-1:0] PRE_HI   = 32'h40f0_f0f0;
  localparam logic [WORD_W-1:0] PRE_LO   = 32'hf0fd_ffff;
  localparam logic [WORD_W-1:0] BOOT_HI  = 32'h40ff_ffff;
  localparam logic [WORD_W-1:0] BOOT_LO  = 32'hfae5_ffff;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_NONE     = 2'd0,
    CMD_IDLE     = 2'd1,
    CMD_PRE_IDLE = 2'd2,
    CMD_BOOT     = 2'd3
  } cmd_t;

  typedef struct packed {
    word_t word3;
    word_t word2;
    word_t word1;
    word_t word0;
  } in_t;

  typedef struct packed {
    cmd_t             command;
    logic [POS_W-1:0] position;
  } out_t;

  // What one lane found at its start position
  typedef struct packed {
    logic hit;
    cmd_t cmd;
  } lane_res_t;

  // First received byte becomes most significant
  function automatic word_t swap_bytes(input word_t v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // Ring positions without an input word read as an idle bus
  function automatic word_t ring_word(input in_t d, input int pos);
    word_t w;
    case (pos)
      0:       w = d.word0;
      1:       w = d.word1;
      2:       w = d.word2;
      3:       w = d.word3;
      default: w = ALL_ONES;
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/emmc_boot_command_detect_top.sv -----
// Top level of the eMMC boot command detector: one lane per ring position,
// a lane result register and the merge stage.
// Depends on ebcd_pkg, ebcd_lane, ebcd_merge.
`timescale 1ns / 1ps

// Takes one snapshot of the four-word SPI ring per transaction and returns
// one result: the first of the go-idle, go-pre-idle or boot-start commands
// found, scanning start positions upward, and the position where it starts
// (0 and 0 when nothing matches). A new snapshot is accepted every cycle
// while the lane result register can take it; each snapshot passes through
// the per-position lanes (byte swap, start-bit alignment and compare) into
// the lane result register, then through the merge stage, which picks the
// lowest matching position, into the output register. Both registers hold
// their data under backpressure, so a stalled result never drops a snapshot.
module emmc_boot_command_detect_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ebcd_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ebcd_pkg::out_t   out_data
);
  import ebcd_pkg::*;

  lane_res_t [RING_WORDS-1:0] lane_res;
  lane_res_t [RING_WORDS-1:0] lane_r;
  logic                       lane_valid_r;
  logic                       lane_valid_nxt;
  logic                       merge_ready;
  logic                       load;

  // One lane per ring position, each looking at its word and the next two
  for (genvar g = 0; g < RING_WORDS; g++) begin : g_lane
    ebcd_lane u_lane (
      .word_a (ring_word(in_data, g)),
      .word_b (ring_word(in_data, (g + 1) % RING_WORDS)),
      .word_c (ring_word(in_data, (g + 2) % RING_WORDS)),
      .res    (lane_res[g])
    );
  end

  // Lane result register
  assign in_ready       = !lane_valid_r || merge_ready;
  assign load           = in_valid && in_ready;
  assign lane_valid_nxt = load ? 1'b1 : (lane_valid_r && !merge_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_valid_r <= 1'b0;
    end else begin
      lane_valid_r <= lane_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lane_r <= lane_res;
    end
  end

  ebcd_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .lanes_valid (lane_valid_r),
    .lanes_ready (merge_ready),
    .lanes       (lane_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ----- hw/rtl/ebcd_lane.sv -----
// One detection lane: aligns the words at one ring position on the '01'
// start bits and compares the leading 64 bits with the command patterns.
// Depends on ebcd_pkg.
`timescale 1ns / 1ps

module ebcd_lane (
  input  ebcd_pkg::word_t     word_a,
  input  ebcd_pkg::word_t     word_b,
  input  ebcd_pkg::word_t     word_c,
  output ebcd_pkg::lane_res_t res
);
  import ebcd_pkg::*;

  word_t      a_sw;
  word_t      b_sw;
  word_t      c_sw;
  logic [5:0] lead_ones;
  logic [95:0] cat;
  logic [95:0] shifted;
  word_t      hi;
  word_t      lo;
  cmd_t       cmd;

  assign a_sw = swap_bytes(word_a);
  assign b_sw = swap_bytes(word_b);
  assign c_sw = swap_bytes(word_c);

  // Leading ones of the first word: 31 minus the highest zero bit
  always_comb begin
    lead_ones = 6'd32;
    for (int i = 0; i < WORD_W; i++) begin
      if (!a_sw[i]) lead_ones = 6'(31 - i);
    end
  end

  // Shift out the leading ones, filling from the following words.
  // A top byte of 0x40 already has no leading ones.
  assign cat     = {a_sw, b_sw, c_sw};
  assign shifted = lead_ones[5] ? cat : (cat << lead_ones[4:0]);
  assign hi      = shifted[95:64];
  assign lo      = shifted[63:32];

  // Pattern compare in priority order
  always_comb begin
    if (hi == IDLE_HI && lo == IDLE_LO) begin
      cmd = CMD_IDLE;
    end else if (hi == PRE_HI && lo == PRE_LO) begin
      cmd = CMD_PRE_IDLE;
    end else if (hi == BOOT_HI && lo == BOOT_LO) begin
      cmd = CMD_BOOT;
    end else begin
      cmd = CMD_NONE;
    end
  end

  // Idle-bus start words are never a command start
  assign res.hit = (word_a != ALL_ONES) && (cmd != CMD_NONE);
  assign res.cmd = cmd;

endmodule

// ----- hw/rtl/ebcd_merge.sv -----
// Merge stage: picks the lowest ring position with a hit and holds the
// result in the output register.
// Depends on ebcd_pkg.
`timescale 1ns / 1ps

module ebcd_merge (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         lanes_valid,
  output logic                                         lanes_ready,
  input  ebcd_pkg::lane_res_t [ebcd_pkg::RING_WORDS-1:0] lanes,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output ebcd_pkg::out_t                               out_data
);
  import ebcd_pkg::*;

  logic out_valid_r;
  logic out_valid_nxt;
  out_t out_r;
  out_t out_nxt;
  logic load;
  logic any_hit;

  // First hit wins; scan from the top so the lowest position overrides
  always_comb begin
    out_nxt.command  = CMD_NONE;
    out_nxt.position = '0;
    any_hit          = 1'b0;
    for (int i = RING_WORDS - 1; i >= 0; i--) begin
      if (lanes[i].hit) begin
        out_nxt.command  = lanes[i].cmd;
        out_nxt.position = POS_W'(i);
        any_hit          = 1'b1;
      end
    end
  end

  assign lanes_ready   = !out_valid_r || out_ready;
  assign load          = lanes_valid && lanes_ready;
  assign out_valid_nxt = load ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // No command means position zero
  a_none_pos0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.command == CMD_NONE |-> out_r.position == '0)
    else $error("no-match result with nonzero position");

  // A transaction with no lane hit reports no command
  a_nohit_none: assert property (@(posedge clk) disable iff (!rst_n)
    load && !any_hit |=> out_r.command == CMD_NONE)
    else $error("command reported without any lane hit");

  // A result waiting on the sink is held
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_r))
    else $error("stalled result changed");

endmodule
